// ===== rtl/core/perfect_hash_index_lookup_unit_assert.svh =====
// Assertion macros for the perfect hash index lookup unit.
// Included by the top level, which checks its own logic; needs no package.
`ifndef PERFECT_HASH_INDEX_LOOKUP_UNIT_ASSERT_SVH
`define PERFECT_HASH_INDEX_LOOKUP_UNIT_ASSERT_SVH
`ifndef SYNTH
`define PHIL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property violated");
`define PHIL_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define PHIL_ASSERT(lbl, clk, rst, prop)
`define PHIL_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== rtl/core/phil_pkg.sv =====
// Shared types, constants and the hash mix step of the lookup unit.
// Used by every module in rtl/core; depends on nothing else.
package phil_pkg;

   localparam int unsigned TABLE_DEPTH_DEFAULT = 4096;
   localparam int unsigned QUEUE_DEPTH = 16;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SLOT_W = 16;
   localparam int unsigned NUM_MIX = 9;

   localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;

   localparam int unsigned Y_SHIFT = 7;
   localparam int unsigned Y_ADD = 3;
   localparam int unsigned Y_BITS = 7;
   localparam int unsigned Z_SHIFT = 5;
   localparam int unsigned Z_ADD = 9;
   localparam int unsigned Z_BITS = 5;
   localparam int unsigned GUARD_SHIFT = 4;

   typedef enum logic {
      MODE_LOOKUP = 1'b0,
      MODE_WRITE  = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      CSR_FIRST_SEED  = 2'd0,
      CSR_SECOND_SEED = 2'd1,
      CSR_SLOT_MASK   = 2'd2,
      CSR_SUM_MASK    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } mix_state_type;

   // One queued word: slot1 doubles as the write slot for table writes.
   typedef struct packed {
      mode_type          mode;
      logic [SLOT_W-1:0] slot1;
      logic [SLOT_W-1:0] slot2;
      logic [31:0]       h1;
      logic [31:0]       h2;
      logic [31:0]       value;
   } queue_entry_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              empty;
   } fifo_status_type;

   // One line of the nine-line mix; each line rewrites exactly one word.
   function automatic mix_state_type mix_line(input int step, input mix_state_type s);
      mix_state_type r;
      r = s;
      case (step)
         0: r.a = (s.a - s.b - s.c) ^ (s.c >> 13);
         1: r.b = (s.b - s.c - s.a) ^ (s.a << 8);
         2: r.c = (s.c - s.a - s.b) ^ (s.b >> 13);
         3: r.a = (s.a - s.b - s.c) ^ (s.c >> 12);
         4: r.b = (s.b - s.c - s.a) ^ (s.a << 16);
         5: r.c = (s.c - s.a - s.b) ^ (s.b >> 5);
         6: r.a = (s.a - s.b - s.c) ^ (s.c >> 3);
         7: r.b = (s.b - s.c - s.a) ^ (s.a << 10);
         8: r.c = (s.c - s.a - s.b) ^ (s.b >> 15);
         default: r = s;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/perfect_hash_index_lookup_unit.sv =====
// Top level of the perfect hash index lookup unit: configuration, credits, assembly.
// Depends on phil_pkg, phil_front, phil_fifo, phil_back and the assertion header.
//
// The unit takes one word per cycle on the req_ channel while req_stall is low. A lookup
// word hashes its key with both seeds, reads two vertex table entries, and raises its
// rsp_ word after the hashing stages, the entry register, the queue, the table read,
// the stages for the index sum and the two guard remainders, and the response
// register; later while rsp_stall is held. A table-write word
// gives no response and is applied to the table in order with the lookups around it.
// req_stall rises when 16 words sit between accept and the table read, the depth of
// the internal queue; it is set by that credit count alone. The table holds no
// defined value until written, so every entry a lookup may address must be written first.
`include "perfect_hash_index_lookup_unit_assert.svh"
module perfect_hash_index_lookup_unit
   import phil_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [31:0] req_key,
   input  logic [11:0] req_table_addr,
   input  logic [31:0] req_table_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_index,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   logic [31:0]       first_seed_ff;
   logic [31:0]       second_seed_ff;
   logic [11:0]       slot_mask_ff;
   logic [31:0]       sum_mask_ff;
   logic [QCNT_W-1:0] credit_ff;
   logic [QCNT_W-1:0] credit_in;
   logic              accept;
   logic              fifo_push;
   logic              fifo_pop;
   queue_entry_type   push_entry;
   queue_entry_type   head;
   fifo_status_type   fifo_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_seed_ff  <= '0;
         second_seed_ff <= '0;
         slot_mask_ff   <= 12'hfff;
         sum_mask_ff    <= 32'h0000_0fff;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_FIRST_SEED:  first_seed_ff  <= csr_write_data;
            CSR_SECOND_SEED: second_seed_ff <= csr_write_data;
            CSR_SLOT_MASK:   slot_mask_ff   <= csr_write_data[11:0];
            CSR_SUM_MASK:    sum_mask_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // One credit per word between accept and the table read keeps the queue from overflowing.
   assign req_stall = (credit_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      credit_in = credit_ff;
      if (accept && !fifo_pop) begin
         credit_in = credit_ff + QCNT_W'(1);
      end else if (fifo_pop && !accept) begin
         credit_in = credit_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   phil_front #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (req_mode),
      .key        (req_key),
      .table_addr (req_table_addr),
      .table_value(req_table_value),
      .first_seed (first_seed_ff),
      .second_seed(second_seed_ff),
      .slot_mask  (slot_mask_ff),
      .push       (fifo_push),
      .push_entry (push_entry)
   );

   phil_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_entry(push_entry),
      .pop       (fifo_pop),
      .head      (head),
      .status    (fifo_status)
   );

   phil_back #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .status          (fifo_status),
      .sum_mask        (sum_mask_ff),
      .rsp_stall       (rsp_stall),
      .pop             (fifo_pop),
      .rsp_valid       (rsp_valid),
      .rsp_result_index(rsp_result_index)
   );

   `PHIL_ASSERT(a_credit_bound, clock, reset, credit_ff <= QCNT_W'(QUEUE_DEPTH))
   `PHIL_ASSERT(a_queue_within_credit, clock, reset, fifo_status.count <= credit_ff)
   `PHIL_ASSERT_NEVER(a_no_pop_when_empty, clock, reset, fifo_pop && fifo_status.empty)

endmodule

// ===== rtl/core/phil_front.sv =====
// Front part: registers accepted words and runs both hashes, one mix line per stage.
// Depends on phil_pkg; feeds phil_fifo with table slots and hash words.
module phil_front
   import phil_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic            mode,
   input  logic [31:0]     key,
   input  logic [11:0]     table_addr,
   input  logic [31:0]     table_value,
   input  logic [31:0]     first_seed,
   input  logic [31:0]     second_seed,
   input  logic [11:0]     slot_mask,
   output logic            push,
   output queue_entry_type push_entry
);

   typedef struct packed {
      mode_type      mode;
      logic [11:0]   addr;
      logic [31:0]   value;
      mix_state_type m1;
      mix_state_type m2;
   } front_stage_type;

   logic [NUM_MIX:0]  valid_ff;
   front_stage_type   stage_ff [NUM_MIX+1];
   front_stage_type   stage_in [NUM_MIX+1];
   logic              push_ff;
   queue_entry_type   entry_ff;
   queue_entry_type   entry_in;

   // Reduces a 12-bit address modulo the table depth by conditional subtraction.
   function automatic logic [SLOT_W-1:0] to_slot(input logic [11:0] v);
      logic [12:0] r;
      r = {1'b0, v};
      for (int k = 11; k >= 0; k--) begin
         if ((TABLE_DEPTH << k) <= 4095) begin
            if (32'(r) >= (TABLE_DEPTH << k)) begin
               r = r - 13'(TABLE_DEPTH << k);
            end
         end
      end
      return SLOT_W'(r);
   endfunction

   always_comb begin
      stage_in[0].mode  = mode_type'(mode);
      stage_in[0].addr  = table_addr;
      stage_in[0].value = table_value;
      stage_in[0].m1.a  = GOLDEN_WORD + key;
      stage_in[0].m1.b  = GOLDEN_WORD;
      stage_in[0].m1.c  = first_seed;
      stage_in[0].m2.a  = GOLDEN_WORD + key;
      stage_in[0].m2.b  = GOLDEN_WORD;
      stage_in[0].m2.c  = second_seed;
      for (int k = 1; k <= NUM_MIX; k++) begin
         stage_in[k]    = stage_ff[k-1];
         stage_in[k].m1 = mix_line(k - 1, stage_ff[k-1].m1);
         stage_in[k].m2 = mix_line(k - 1, stage_ff[k-1].m2);
      end
   end

   always_comb begin
      entry_in.mode  = stage_ff[NUM_MIX].mode;
      entry_in.h1    = stage_ff[NUM_MIX].m1.c;
      entry_in.h2    = stage_ff[NUM_MIX].m2.c;
      entry_in.value = stage_ff[NUM_MIX].value;
      entry_in.slot2 = to_slot(stage_ff[NUM_MIX].m2.c[11:0] & slot_mask);
      if (stage_ff[NUM_MIX].mode == MODE_WRITE) begin
         entry_in.slot1 = to_slot(stage_ff[NUM_MIX].addr);
      end else begin
         entry_in.slot1 = to_slot(stage_ff[NUM_MIX].m1.c[11:0] & slot_mask);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         push_ff  <= 1'b0;
      end else begin
         valid_ff <= {valid_ff[NUM_MIX-1:0], accept};
         push_ff  <= valid_ff[NUM_MIX];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NUM_MIX; k++) begin
         stage_ff[k] <= stage_in[k];
      end
      entry_ff <= entry_in;
   end

   assign push       = push_ff;
   assign push_entry = entry_ff;

endmodule

// ===== rtl/core/phil_fifo.sv =====
// Short queue between the hash front part and the table/guard back part.
// Depends on phil_pkg; space is guaranteed by the credit counter at the top level.
module phil_fifo
   import phil_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output queue_entry_type head,
   output fifo_status_type status
);

   queue_entry_type   slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff;
   logic [QPTR_W-1:0] rptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wptr_ff] <= push_entry;
      end
   end

   assign head         = slots_ff[rptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);

endmodule

// ===== rtl/core/phil_back.sv =====
// Back part: vertex table, index sum, the two guard remainders and the response register.
// Depends on phil_pkg; pulls words from phil_fifo whenever its pipeline can move.
module phil_back
   import phil_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  queue_entry_type head,
   input  fifo_status_type status,
   input  logic [31:0]     sum_mask,
   input  logic            rsp_stall,
   output logic            pop,
   output logic            rsp_valid,
   output logic [31:0]     rsp_result_index
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned DYW = 32 - Y_SHIFT + 1;
   localparam int unsigned DZW = 32 - Z_SHIFT + 1;

   typedef struct packed {
      logic [31:0]    idx;
      logic [31:0]    ry;
      logic [31:0]    rz;
      logic [DYW-1:0] dy;
      logic [DZW-1:0] dz;
   } div_stage_type;

   logic [31:0]    table_mem [TABLE_DEPTH];
   logic [31:0]    rd1_ff;
   logic [31:0]    rd2_ff;
   logic           look_ff;
   logic [31:0]    h1_ff;
   logic [31:0]    h2_ff;
   logic [Y_BITS:0] dvalid_ff;
   div_stage_type  div_ff [Y_BITS+1];
   div_stage_type  div_in [Y_BITS+1];
   logic           adv;
   logic [31:0]    sum;
   logic [31:0]    guard;
   logic [31:0]    result;
   logic           rsp_valid_ff;
   logic [31:0]    rsp_data_ff;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign pop = adv && !status.empty;

   // Reads and writes happen in queue order at the pop, so no write overtakes a lookup.
   always_ff @(posedge clock) begin
      if (pop) begin
         if (head.mode == MODE_WRITE) begin
            table_mem[head.slot1[AW-1:0]] <= head.value;
         end
         rd1_ff <= table_mem[head.slot1[AW-1:0]];
         rd2_ff <= table_mem[head.slot2[AW-1:0]];
         h1_ff  <= head.h1;
         h2_ff  <= head.h2;
      end
   end

   always_comb begin
      div_in[0].idx = (rd1_ff + rd2_ff) & sum_mask;
      div_in[0].ry  = h1_ff;
      div_in[0].rz  = h2_ff;
      div_in[0].dy  = DYW'(h1_ff >> Y_SHIFT) + DYW'(Y_ADD);
      div_in[0].dz  = DZW'(h2_ff >> Z_SHIFT) + DZW'(Z_ADD);
   end

   // Each stage settles one quotient bit; the quotients stay below 2^7 and 2^5.
   for (genvar k = 0; k < Y_BITS; k++) begin : g_div
      localparam int unsigned YB = Y_BITS - 1 - k;
      logic [32:0] ty;
      logic [32:0] tz;
      assign ty = 33'(div_ff[k].dy) << YB;
      always_comb begin
         div_in[k+1] = div_ff[k];
         if ({1'b0, div_ff[k].ry} >= ty) begin
            div_in[k+1].ry = div_ff[k].ry - ty[31:0];
         end
         if (k < Z_BITS) begin
            if ({1'b0, div_ff[k].rz} >= tz) begin
               div_in[k+1].rz = div_ff[k].rz - tz[31:0];
            end
         end
      end
      if (k < Z_BITS) begin : g_z
         assign tz = 33'(div_ff[k].dz) << (Z_BITS - 1 - k);
      end else begin : g_nz
         assign tz = '1;
      end
   end

   assign sum    = div_ff[Y_BITS].ry + div_ff[Y_BITS].rz;
   assign guard  = sum << GUARD_SHIFT;
   assign result = (guard > div_ff[Y_BITS].idx) ? div_ff[Y_BITS].idx : div_ff[Y_BITS].ry;

   always_ff @(posedge clock) begin
      if (reset) begin
         look_ff      <= 1'b0;
         dvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         look_ff      <= pop && (head.mode == MODE_LOOKUP);
         dvalid_ff    <= {dvalid_ff[Y_BITS-1:0], look_ff};
         rsp_valid_ff <= dvalid_ff[Y_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= Y_BITS; k++) begin
            div_ff[k] <= div_in[k];
         end
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_data_ff;

endmodule
